// ===== src/tmtr_pkg.sv =====
// ----------------------------------------------------------------------------
// tmtr_pkg
// Shared types, codes and widths of the tempo map tick rescaler.
// ----------------------------------------------------------------------------
package tmtr_pkg;

  // Table geometry
  localparam int TEMPO_ENTRIES = 64;
  localparam int IDX_W         = $clog2(TEMPO_ENTRIES);
  localparam int CNT_W         = $clog2(TEMPO_ENTRIES + 1);

  // Field widths
  localparam int TICK_W  = 31;
  localparam int TEMPO_W = 24;
  localparam int ENTRY_W = TICK_W + TEMPO_W;
  localparam int PROD_W  = TICK_W + TEMPO_W;

  // Divider geometry: product with 32 fraction bits over a 25-bit divisor
  localparam int FRAC_W  = 32;
  localparam int NUM_W   = PROD_W + FRAC_W;
  localparam int DEN_W   = TEMPO_W + 1;
  localparam int DCNT_W  = $clog2(NUM_W + 1);

  // Accumulator whole part, capped at 2^33
  localparam int WHOLE_W = 34;
  localparam logic [WHOLE_W-1:0] ACC_CAP  = 34'h2_0000_0000;
  localparam logic [TICK_W-1:0]  TICK_MAX = 31'h7FFF_FFFF;

  // Front queue
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QFILL_W = $clog2(QDEPTH + 1);

  // Opcodes
  localparam logic [1:0] OP_CLEAR   = 2'd0;
  localparam logic [1:0] OP_APPEND  = 2'd1;
  localparam logic [1:0] OP_CONVERT = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_COLLAPSE = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  typedef enum logic [1:0] {
    CLS_CLEAR,
    CLS_APPEND,
    CLS_CONVERT,
    CLS_NOP
  } tmtr_cls_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [TICK_W-1:0]  tick;
    logic [TEMPO_W-1:0] tempo_milli_bpm;
    logic [TICK_W-1:0]  duration;
  } tmtr_in_t;

  typedef struct packed {
    logic [TICK_W-1:0] new_start_tick;
    logic [TICK_W-1:0] new_duration;
    logic [1:0]        status;
  } tmtr_out_t;

  // Queue entry: classified item
  typedef struct packed {
    tmtr_cls_t cls;
    tmtr_in_t  item;
  } tmtr_q_t;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } tmtr_div_stat_t;

endpackage

// ===== src/tmtr_ram.sv =====
// ----------------------------------------------------------------------------
// tmtr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tmtr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and register the read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/tmtr_front.sv =====
// ----------------------------------------------------------------------------
// tmtr_front
// Accepts input beats, classifies the opcode and holds items in a short queue.
// ----------------------------------------------------------------------------
module tmtr_front import tmtr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  tmtr_in_t in_data,
  output logic     q_valid,
  output tmtr_q_t  q_data,
  input  logic     q_pop
);

  tmtr_q_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [QFILL_W-1:0]   fill_r, fill_nxt;
  logic                 push;
  tmtr_cls_t            cls;

  // Classify the opcode
  always_comb begin
    unique case (in_data.opcode)
      OP_CLEAR:   cls = CLS_CLEAR;
      OP_APPEND:  cls = CLS_APPEND;
      OP_CONVERT: cls = CLS_CONVERT;
      default:    cls = CLS_NOP;
    endcase
  end

  assign in_stall = (fill_r == QFILL_W'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (fill_r != '0);
  assign q_data   = mem_r[rd_ptr_r];

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    fill_nxt   = fill_r;
    if (push && !q_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (!push && q_pop) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Store the classified beat
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= '{cls: cls, item: in_data};
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= QFILL_W'(QDEPTH))
    else $error("queue fill above depth");

  a_fill_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !q_pop) |=> fill_r == $past(fill_r) + 1'b1)
    else $error("queue fill did not advance on push");

  a_fill_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && !push) |=> fill_r == $past(fill_r) - 1'b1)
    else $error("queue fill did not drop on pop");

endmodule

// ===== src/tmtr_div.sv =====
// ----------------------------------------------------------------------------
// tmtr_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tmtr_div import tmtr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo,
  output tmtr_div_stat_t   stat
);

  logic [NUM_W-1:0]  quo_r, quo_nxt;
  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DEN_W:0]    rem_sh;
  logic [DEN_W:0]    rem_sub;
  logic              ge;

  assign rem_sh  = {rem_r, quo_r[NUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_r};
  assign ge      = (rem_sh >= {1'b0, den_r});

  // Load the operands on start, else shift one bit of the numerator into the remainder
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = num;
      rem_nxt  = '0;
      den_nxt  = den;
      cnt_nxt  = DCNT_W'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[NUM_W-2:0], ge};
      rem_nxt = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign quo  = quo_r;
  assign stat = '{busy: busy_r, done: done_r};

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && $past(busy_r))
    else $error("divider done without a finished run");

  a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r != '0)
    else $error("divider busy with empty count");

endmodule

// ===== src/tmtr_back.sv =====
// ----------------------------------------------------------------------------
// tmtr_back
// Sequencer: keeps the tempo table, walks segments for a convert and
// delivers one result beat per item through an output register.
// ----------------------------------------------------------------------------
module tmtr_back import tmtr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  tmtr_q_t   q_data,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output tmtr_out_t out_data
);

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_NXT  = 11'b000_0000_0010,
    S_RD   = 11'b000_0000_0100,
    S_CHK  = 11'b000_0000_1000,
    S_TAIL = 11'b000_0001_0000,
    S_MUL  = 11'b000_0010_0000,
    S_DLD  = 11'b000_0100_0000,
    S_DIV  = 11'b000_1000_0000,
    S_ACC  = 11'b001_0000_0000,
    S_DUR  = 11'b010_0000_0000,
    S_FIN  = 11'b100_0000_0000
  } tmtr_state_t;

  tmtr_state_t        st_r, st_nxt;
  tmtr_in_t           item_r, item_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [TEMPO_W-1:0] main_r, main_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic [TICK_W-1:0]  prev_t_r, prev_t_nxt;
  logic [TEMPO_W-1:0] prev_b_r, prev_b_nxt;
  logic [TEMPO_W-1:0] loc_r, loc_nxt;
  logic               walk_done_r, walk_done_nxt;
  logic               loc_done_r, loc_done_nxt;
  logic [TICK_W-1:0]  len_r, len_nxt;
  logic [TEMPO_W-1:0] seg_r, seg_nxt;
  logic               tail_r, tail_nxt;
  logic               dmode_r, dmode_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  logic [WHOLE_W-1:0] whole_r, whole_nxt;
  logic [FRAC_W-1:0]  frac_r, frac_nxt;
  logic [TICK_W-1:0]  ns_r, ns_nxt;
  logic [TICK_W-1:0]  nd_r, nd_nxt;
  logic [1:0]         stat_r, stat_nxt;
  logic               out_valid_r, out_valid_nxt;
  tmtr_out_t          out_r, out_nxt;

  logic               ram_we;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [TICK_W-1:0]  ent_tick;
  logic [TEMPO_W-1:0] ent_tempo;
  logic               div_start;
  logic [NUM_W-1:0]   div_num;
  logic [DEN_W-1:0]   div_den;
  logic [NUM_W-1:0]   div_quo;
  tmtr_div_stat_t     div_stat;
  logic [TICK_W-1:0]  mul_a;
  logic [PROD_W-1:0]  prod_c;
  logic [NUM_W:0]     acc_sum;
  logic [NUM_W-FRAC_W:0] acc_whole;
  logic [WHOLE_W:0]   start_res;
  logic               out_free;

  // Tempo table
  assign ram_we = (st_r == S_IDLE) && q_valid && (q_data.cls == CLS_APPEND) &&
                  (cnt_r < CNT_W'(TEMPO_ENTRIES));

  tmtr_ram #(.WIDTH(ENTRY_W), .DEPTH(TEMPO_ENTRIES)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[IDX_W-1:0]),
    .wdata ({q_data.item.tick, q_data.item.tempo_milli_bpm}),
    .raddr (idx_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  assign ent_tick  = ram_rdata[ENTRY_W-1:TEMPO_W];
  assign ent_tempo = ram_rdata[TEMPO_W-1:0];

  // Shared divider: segment stretch or duration rescale
  assign div_start = (st_r == S_DLD);
  always_comb begin
    if (dmode_r) begin
      div_num = NUM_W'({prod_r, 1'b0}) + NUM_W'(loc_r);
      div_den = {loc_r, 1'b0};
    end else begin
      div_num = {prod_r, {FRAC_W{1'b0}}} + NUM_W'(seg_r >> 1);
      div_den = {1'b0, seg_r};
    end
  end

  tmtr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .stat  (div_stat)
  );

  // Multiply by the main tempo
  assign mul_a  = dmode_r ? item_r.duration : len_r;
  assign prod_c = PROD_W'(mul_a) * PROD_W'(main_r);

  // Accumulate the stretched segment
  assign acc_sum   = {{(NUM_W - WHOLE_W - FRAC_W + 1){1'b0}}, whole_r, frac_r} +
                     {1'b0, div_quo};
  assign acc_whole = acc_sum[NUM_W:FRAC_W];

  // Round the accumulator to a tick
  assign start_res = {1'b0, whole_r} + (WHOLE_W + 1)'(frac_r[FRAC_W-1]);

  assign out_free = !out_valid_r || !out_stall;
  assign q_pop    = (st_r == S_IDLE) && q_valid;

  always_comb begin
    st_nxt        = st_r;
    item_nxt      = item_r;
    cnt_nxt       = cnt_r;
    main_nxt      = main_r;
    idx_nxt       = idx_r;
    prev_t_nxt    = prev_t_r;
    prev_b_nxt    = prev_b_r;
    loc_nxt       = loc_r;
    walk_done_nxt = walk_done_r;
    loc_done_nxt  = loc_done_r;
    len_nxt       = len_r;
    seg_nxt       = seg_r;
    tail_nxt      = tail_r;
    dmode_nxt     = dmode_r;
    prod_nxt      = prod_r;
    whole_nxt     = whole_r;
    frac_nxt      = frac_r;
    ns_nxt        = ns_r;
    nd_nxt        = nd_r;
    stat_nxt      = stat_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;

    unique case (st_r)
      S_IDLE: begin
        if (q_valid) begin
          item_nxt = q_data.item;
          ns_nxt   = '0;
          nd_nxt   = '0;
          stat_nxt = ST_OK;
          st_nxt   = S_FIN;
          case (q_data.cls)
            CLS_CLEAR: begin
              cnt_nxt = '0;
            end
            CLS_APPEND: begin
              if (cnt_r < CNT_W'(TEMPO_ENTRIES)) begin
                if (cnt_r == '0) begin
                  main_nxt = q_data.item.tempo_milli_bpm;
                end
                cnt_nxt = cnt_r + 1'b1;
              end else begin
                stat_nxt = ST_FULL;
              end
            end
            CLS_CONVERT: begin
              if (cnt_r == '0 || main_r == '0) begin
                ns_nxt = q_data.item.tick;
                nd_nxt = q_data.item.duration;
              end else begin
                idx_nxt       = '0;
                prev_t_nxt    = '0;
                prev_b_nxt    = main_r;
                loc_nxt       = main_r;
                walk_done_nxt = 1'b0;
                loc_done_nxt  = 1'b0;
                tail_nxt      = 1'b0;
                dmode_nxt     = 1'b0;
                whole_nxt     = '0;
                frac_nxt      = '0;
                st_nxt        = S_NXT;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Walk on while entries remain and either search is still open
      S_NXT: begin
        if (idx_r < cnt_r && !(walk_done_r && loc_done_r)) begin
          st_nxt = S_RD;
        end else begin
          st_nxt = S_TAIL;
        end
      end

      S_RD: begin
        st_nxt = S_CHK;
      end

      S_CHK: begin
        idx_nxt = idx_r + 1'b1;
        st_nxt  = S_NXT;
        if (!loc_done_r) begin
          if (ent_tick <= item_r.tick) begin
            loc_nxt = ent_tempo;
          end else begin
            loc_done_nxt = 1'b1;
          end
        end
        if (!walk_done_r) begin
          if (ent_tick >= item_r.tick) begin
            walk_done_nxt = 1'b1;
          end else begin
            if (prev_b_r != '0 && ent_tick > prev_t_r) begin
              len_nxt   = ent_tick - prev_t_r;
              seg_nxt   = prev_b_r;
              dmode_nxt = 1'b0;
              st_nxt    = S_MUL;
            end
            prev_t_nxt = ent_tick;
            prev_b_nxt = ent_tempo;
          end
        end
      end

      // Last segment up to the note tick
      S_TAIL: begin
        tail_nxt = 1'b1;
        if (prev_b_r != '0 && item_r.tick > prev_t_r) begin
          len_nxt   = item_r.tick - prev_t_r;
          seg_nxt   = prev_b_r;
          dmode_nxt = 1'b0;
          st_nxt    = S_MUL;
        end else begin
          st_nxt = S_DUR;
        end
      end

      S_MUL: begin
        prod_nxt = prod_c;
        st_nxt   = S_DLD;
      end

      S_DLD: begin
        st_nxt = S_DIV;
      end

      S_DIV: begin
        if (div_stat.done) begin
          if (dmode_r) begin
            if (div_quo == '0) begin
              nd_nxt   = TICK_W'(1);
              stat_nxt = ST_COLLAPSE;
            end else if (div_quo > NUM_W'(TICK_MAX)) begin
              nd_nxt = TICK_MAX;
            end else begin
              nd_nxt = div_quo[TICK_W-1:0];
            end
            st_nxt = S_FIN;
          end else begin
            st_nxt = S_ACC;
          end
        end
      end

      // Add the segment, cap the whole part
      S_ACC: begin
        frac_nxt = acc_sum[FRAC_W-1:0];
        if (acc_whole > (NUM_W - FRAC_W + 1)'(ACC_CAP)) begin
          whole_nxt = ACC_CAP;
        end else begin
          whole_nxt = acc_whole[WHOLE_W-1:0];
        end
        st_nxt = tail_r ? S_DUR : S_NXT;
      end

      S_DUR: begin
        if (start_res > (WHOLE_W + 1)'(TICK_MAX)) begin
          ns_nxt = TICK_MAX;
        end else begin
          ns_nxt = start_res[TICK_W-1:0];
        end
        if (loc_r != '0 && loc_r != main_r) begin
          dmode_nxt = 1'b1;
          st_nxt    = S_MUL;
        end else begin
          nd_nxt = item_r.duration;
          st_nxt = S_FIN;
        end
      end

      // Hand the result to the output register
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{new_start_tick: ns_r, new_duration: nd_r, status: stat_r};
          st_nxt        = S_IDLE;
        end
      end

      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    main_r      <= main_nxt;
    idx_r       <= idx_nxt;
    prev_t_r    <= prev_t_nxt;
    prev_b_r    <= prev_b_nxt;
    loc_r       <= loc_nxt;
    walk_done_r <= walk_done_nxt;
    loc_done_r  <= loc_done_nxt;
    len_r       <= len_nxt;
    seg_r       <= seg_nxt;
    tail_r      <= tail_nxt;
    dmode_r     <= dmode_nxt;
    prod_r      <= prod_nxt;
    whole_r     <= whole_nxt;
    frac_r      <= frac_nxt;
    ns_r        <= ns_nxt;
    nd_r        <= nd_nxt;
    stat_r      <= stat_nxt;
    out_r       <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(TEMPO_ENTRIES))
    else $error("entry count above table depth");

  a_div_live: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_DIV |-> div_stat.busy || div_stat.done)
    else $error("waiting on an idle divider");

  a_collapse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status == ST_COLLAPSE |-> out_r.new_duration == TICK_W'(1))
    else $error("collapsed duration not forced to one");

endmodule

// ===== src/tempo_map_tick_rescaler.sv =====
// ----------------------------------------------------------------------------
// tempo_map_tick_rescaler
// Tempo table with clear/append loading and note tick conversion onto the
// main tempo.
//
//   channel | ports                           | beat
//   --------+---------------------------------+---------------------------
//   input   | in_valid, in_stall, in_data     | opcode, tick, tempo, dur
//   output  | out_valid, out_stall, out_data  | start, duration, status
//
// Clear, append and pass-through items go straight from idle to the finish
// state in the back end. A convert reads each table entry it needs; every
// nonzero segment, the tail segment included, passes multiply, divider load,
// divider steps plus done and accumulate, and a duration rescale passes
// multiply, divider load and divider steps.
// Reset (rst_n low, synchronous) empties the table and the queue at once.
// A two-beat queue keeps accepting until full while the back end works or
// the output register is stalled.
// ----------------------------------------------------------------------------
module tempo_map_tick_rescaler import tmtr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  tmtr_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output tmtr_out_t out_data
);

  logic    q_valid;
  logic    q_pop;
  tmtr_q_t q_data;

  // Accept and classify
  tmtr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop)
  );

  // Execute and deliver
  tmtr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
